/* src/edf_task_scheduler_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the EDF task scheduler checks
// ----------------------------------------------------------------------------
`ifndef EDF_TASK_SCHEDULER_UNIT_ASSERT_SVH
`define EDF_TASK_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define EDFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edf scheduler check failed");

// next-cycle implication, disabled in reset
`define EDFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edf scheduler check failed");

`endif

/* src/edfs_pkg.sv */
// ----------------------------------------------------------------------------
// edfs_pkg
// Shared constants, codes and types of the EDF task scheduler.
// ----------------------------------------------------------------------------
package edfs_pkg;

    // task setup registers
    localparam int CFG_COUNT    = 8;
    localparam int CFG_AW       = 3;
    localparam int CFG_WIDTH    = 33;
    localparam int BUDGET_LSB   = 16;
    localparam int PERIODIC_BIT = 32;

    // parameter defaults
    localparam int DEF_NUM_TASKS   = 8;
    localparam int DEF_QUEUE_DEPTH = 32;
    localparam int DEF_TICK_WIDTH  = 32;
    localparam int DEF_SPAN_WIDTH  = 16;

    // last sporadic release after reset
    localparam int SPORADIC_START = -100;

    // result field widths
    localparam int TASK_W  = 3;
    localparam int TOTAL_W = 32;
    localparam int GRANT_W = 8;
    localparam int SMALL_W = 6;
    localparam int OVF_W   = 4;

    typedef logic [1:0] outcome_t;
    localparam outcome_t OUT_IDLE = 2'd0;
    localparam outcome_t OUT_RUN  = 2'd1;
    localparam outcome_t OUT_DONE = 2'd2;
    localparam outcome_t OUT_MISS = 2'd3;

    // job store commands
    typedef struct packed {
        logic wr_entry;
        logic wr_rem;
        logic set_vld;
        logic clr_vld;
    } store_ctl_t;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

/* src/edf_task_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// edf_task_scheduler_unit
// Earliest-deadline-first scheduler; one command is one time tick.
// ----------------------------------------------------------------------------
// Usage:
//   Configure tasks through wr_en/wr_addr/wr_data (one 33-bit setup word per
//   task: period, budget, periodic flag) while the block is idle.
//   Raise start with sporadic_grant while busy is low to run one tick.
//   The tick runs as a sequence: a release step for each task, then the
//   expiry and earliest-deadline scan of the job store (one memory read
//   issued per slot, then a drain of the last read), then a service step.
//   done pulses for one cycle after the service step; the result ports
//   hold until the next tick.
//   The next start is taken at the edge that ends the done cycle.
//   The result is offered once and must be taken in that cycle.
//   Reset clears the setup words, tick counter, phases, job valid flags and
//   totals; no clearing pass is needed.
// ----------------------------------------------------------------------------
module edf_task_scheduler_unit #(
    parameter int NUM_TASKS   = edfs_pkg::DEF_NUM_TASKS,
    parameter int QUEUE_DEPTH = edfs_pkg::DEF_QUEUE_DEPTH,
    parameter int TICK_WIDTH  = edfs_pkg::DEF_TICK_WIDTH,
    parameter int SPAN_WIDTH  = edfs_pkg::DEF_SPAN_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    output logic                         done,
    input  logic                         wr_en,
    input  logic [edfs_pkg::CFG_AW-1:0]    wr_addr,
    input  logic [edfs_pkg::CFG_WIDTH-1:0] wr_data,
    input  logic [edfs_pkg::GRANT_W-1:0] sporadic_grant,
    output logic                         served_valid,
    output logic [edfs_pkg::TASK_W-1:0]  served_task,
    output logic [1:0]                   service_outcome,
    output logic [edfs_pkg::GRANT_W-1:0] released_mask,
    output logic [edfs_pkg::SMALL_W-1:0] expired_now,
    output logic [edfs_pkg::OVF_W-1:0]   overflow_now,
    output logic [edfs_pkg::SMALL_W-1:0] jobs_pending,
    output logic [edfs_pkg::TOTAL_W-1:0] total_completed,
    output logic [edfs_pkg::TOTAL_W-1:0] total_missed,
    output logic [edfs_pkg::TOTAL_W-1:0] total_running
);
    import edfs_pkg::*;

    localparam int TW      = TICK_WIDTH;
    localparam int SW      = SPAN_WIDTH;
    localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
    localparam int SCAN_W  = SLOT_W + 1;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CW      = (CNT_W > SMALL_W) ? CNT_W : SMALL_W;
    localparam int TIDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int DIFF_W  = TW + 2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_REL   = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_SERVE = 2'd3;

    // control and tick state
    logic [1:0]               state_reg, state_next;
    logic [CFG_WIDTH-1:0]     setup_reg [CFG_COUNT];
    logic [CFG_WIDTH-1:0]     setup_next [CFG_COUNT];
    logic [TW-1:0]            tick_reg, tick_next;
    logic [SW-1:0]            phase_reg [NUM_TASKS];
    logic [SW-1:0]            phase_next [NUM_TASKS];
    logic signed [TW:0]       last_reg [NUM_TASKS];
    logic signed [TW:0]       last_next [NUM_TASKS];
    logic [GRANT_W-1:0]       grant_reg, grant_next;
    logic [TIDX_W-1:0]        task_reg, task_next;
    logic [SCAN_W-1:0]        scan_reg, scan_next;
    logic                     pipe_vld_reg, pipe_vld_next;
    logic [SLOT_W-1:0]        pipe_slot_reg, pipe_slot_next;

    // best candidate of the scan
    logic                     best_found_reg, best_found_next;
    logic [SLOT_W-1:0]        best_slot_reg, best_slot_next;
    logic [TW-1:0]            best_dl_reg, best_dl_next;
    logic [TASK_W-1:0]        best_task_reg, best_task_next;
    logic [SW-1:0]            best_rem_reg, best_rem_next;

    // per-tick counts
    logic [CNT_W-1:0]         live_reg, live_next;
    logic [CNT_W-1:0]         exp_reg, exp_next;
    logic [OVF_W-1:0]         ovf_reg, ovf_next;
    logic [GRANT_W-1:0]       rel_reg, rel_next;

    // totals and result words
    logic [TOTAL_W-1:0]       comp_reg, comp_next;
    logic [TOTAL_W-1:0]       miss_reg, miss_next;
    logic [TOTAL_W-1:0]       run_reg, run_next;
    logic                     done_reg, done_next;
    logic                     sv_reg, sv_next;
    logic [TASK_W-1:0]        st_reg, st_next;
    outcome_t                 oc_reg, oc_next;
    logic [GRANT_W-1:0]       rm_reg, rm_next;
    logic [SMALL_W-1:0]       en_reg, en_next;
    logic [OVF_W-1:0]         on_reg, on_next;
    logic [SMALL_W-1:0]       jp_reg, jp_next;

    // job store interface
    store_ctl_t               st_ctl;
    logic [SLOT_W-1:0]        st_wr_slot;
    logic [TW-1:0]            st_wr_dl;
    logic [SW-1:0]            st_wr_rem;
    logic [TASK_W-1:0]        st_wr_task;
    logic [TW-1:0]            rd_dl;
    logic [SW-1:0]            rd_rem;
    logic [TASK_W-1:0]        rd_task;
    logic [QUEUE_DEPTH-1:0]   job_vld;
    logic                     free_found;
    logic [SLOT_W-1:0]        free_slot;

    // release step temporaries
    logic [CFG_WIDTH-1:0]     cur_setup;
    logic [SW-1:0]            cur_period;
    logic [SW-1:0]            cur_budget;
    logic                     cur_periodic;
    logic [SW-1:0]            cur_phase;
    logic signed [DIFF_W-1:0] since_last;
    logic                     spor_ok;
    logic                     fire;
    logic [SW:0]              phase_inc;

    // scan and service temporaries
    logic                     cand_better;
    logic [SW-1:0]            rem_dec;
    logic [CNT_W-1:0]         pend_cnt;
    logic [CW-1:0]            pend_ext;
    logic [CW-1:0]            exp_ext;

    edfs_job_store #(
        .DEPTH (QUEUE_DEPTH),
        .TW    (TW),
        .SW    (SW)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (st_ctl),
        .wr_slot     (st_wr_slot),
        .wr_deadline (st_wr_dl),
        .wr_rem      (st_wr_rem),
        .wr_task     (st_wr_task),
        .rd_slot     (scan_reg[SLOT_W-1:0]),
        .rd_deadline (rd_dl),
        .rd_rem      (rd_rem),
        .rd_task     (rd_task),
        .valid       (job_vld),
        .free_found  (free_found),
        .free_slot   (free_slot)
    );

    // decode the task under release
    always_comb
    begin
        cur_setup    = setup_reg[CFG_AW'(task_reg)];
        cur_period   = cur_setup[SW-1:0];
        cur_budget   = cur_setup[BUDGET_LSB +: SW];
        cur_periodic = cur_setup[PERIODIC_BIT];
        cur_phase    = phase_reg[task_reg];
        since_last   = $signed({2'b00, tick_reg})
                     - $signed({last_reg[task_reg][TW], last_reg[task_reg]});
        spor_ok      = since_last >= $signed(DIFF_W'(cur_period));
        fire         = (cur_period != '0)
                     && (cur_periodic ? (cur_phase == '0)
                                      : (spor_ok && grant_reg[CFG_AW'(task_reg)]));
        phase_inc    = {1'b0, cur_phase} + 1'b1;
        cand_better  = !best_found_reg || (rd_dl < best_dl_reg)
                     || ((rd_dl == best_dl_reg) && (rd_task < best_task_reg));
        rem_dec      = (best_rem_reg == '0) ? '0 : best_rem_reg - 1'b1;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        setup_next      = setup_reg;
        tick_next       = tick_reg;
        phase_next      = phase_reg;
        last_next       = last_reg;
        grant_next      = grant_reg;
        task_next       = task_reg;
        scan_next       = scan_reg;
        pipe_vld_next   = 1'b0;
        pipe_slot_next  = pipe_slot_reg;
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_dl_next    = best_dl_reg;
        best_task_next  = best_task_reg;
        best_rem_next   = best_rem_reg;
        live_next       = live_reg;
        exp_next        = exp_reg;
        ovf_next        = ovf_reg;
        rel_next        = rel_reg;
        comp_next       = comp_reg;
        miss_next       = miss_reg;
        run_next        = run_reg;
        done_next       = 1'b0;
        sv_next         = sv_reg;
        st_next         = st_reg;
        oc_next         = oc_reg;
        rm_next         = rm_reg;
        en_next         = en_reg;
        on_next         = on_reg;
        jp_next         = jp_reg;
        st_ctl          = '0;
        st_wr_slot      = free_slot;
        st_wr_dl        = tick_reg + TW'(cur_period);
        st_wr_rem       = cur_budget;
        st_wr_task      = TASK_W'(task_reg);
        pend_cnt        = live_reg;
        pend_ext        = '0;
        exp_ext         = '0;

        // take setup words at any time
        if (wr_en)
        begin
            setup_next[wr_addr] = wr_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    grant_next = sporadic_grant;
                    task_next  = '0;
                    rel_next   = '0;
                    ovf_next   = '0;
                    state_next = ST_REL;
                end
            end

            ST_REL:
            begin
                // advance phase and release one task
                if (cur_period == '0)
                begin
                    phase_next[task_reg] = '0;
                end
                else
                begin
                    phase_next[task_reg] = (phase_inc >= {1'b0, cur_period})
                                         ? '0 : phase_inc[SW-1:0];
                    if (fire)
                    begin
                        if (!cur_periodic)
                        begin
                            last_next[task_reg] = $signed({1'b0, tick_reg});
                        end
                        rel_next[CFG_AW'(task_reg)] = 1'b1;
                        if (free_found)
                        begin
                            st_ctl.wr_entry = 1'b1;
                            st_ctl.set_vld  = 1'b1;
                        end
                        else
                        begin
                            ovf_next = ovf_reg + 1'b1;
                        end
                    end
                end
                if (task_reg == TIDX_W'(NUM_TASKS - 1))
                begin
                    scan_next       = '0;
                    best_found_next = 1'b0;
                    live_next       = '0;
                    exp_next        = '0;
                    state_next      = ST_SCAN;
                end
                else
                begin
                    task_next = task_reg + 1'b1;
                end
            end

            ST_SCAN:
            begin
                // issue the next slot read
                if (scan_reg < SCAN_W'(QUEUE_DEPTH))
                begin
                    pipe_vld_next  = 1'b1;
                    pipe_slot_next = scan_reg[SLOT_W-1:0];
                    scan_next      = scan_reg + 1'b1;
                end
                // drop expired jobs, track the earliest deadline
                if (pipe_vld_reg && job_vld[pipe_slot_reg])
                begin
                    if ((rd_dl <= tick_reg) && (rd_rem != '0))
                    begin
                        st_ctl.clr_vld = 1'b1;
                        st_wr_slot     = pipe_slot_reg;
                        exp_next       = exp_reg + 1'b1;
                        miss_next      = sat_inc(miss_reg);
                    end
                    else
                    begin
                        live_next = live_reg + 1'b1;
                        if (cand_better)
                        begin
                            best_found_next = 1'b1;
                            best_slot_next  = pipe_slot_reg;
                            best_dl_next    = rd_dl;
                            best_task_next  = rd_task;
                            best_rem_next   = rd_rem;
                        end
                    end
                end
                if ((scan_reg == SCAN_W'(QUEUE_DEPTH)) && !pipe_vld_reg)
                begin
                    state_next = ST_SERVE;
                end
            end

            ST_SERVE:
            begin
                // run the earliest job one unit
                st_wr_slot = best_slot_reg;
                st_wr_rem  = rem_dec;
                if (best_found_reg)
                begin
                    sv_next = 1'b1;
                    st_next = best_task_reg;
                    if (rem_dec == '0)
                    begin
                        oc_next        = OUT_DONE;
                        st_ctl.clr_vld = 1'b1;
                        comp_next      = sat_inc(comp_reg);
                        pend_cnt       = live_reg - 1'b1;
                    end
                    else if (best_dl_reg == tick_reg)
                    begin
                        oc_next        = OUT_MISS;
                        st_ctl.clr_vld = 1'b1;
                        miss_next      = sat_inc(miss_reg);
                        pend_cnt       = live_reg - 1'b1;
                    end
                    else
                    begin
                        oc_next       = OUT_RUN;
                        st_ctl.wr_rem = 1'b1;
                        run_next      = sat_inc(run_reg);
                    end
                end
                else
                begin
                    sv_next = 1'b0;
                    st_next = '0;
                    oc_next = OUT_IDLE;
                end
                pend_ext   = CW'(pend_cnt);
                exp_ext    = CW'(exp_reg);
                jp_next    = (pend_ext > CW'(63)) ? SMALL_W'(63) : pend_ext[SMALL_W-1:0];
                en_next    = (exp_ext > CW'(63)) ? SMALL_W'(63) : exp_ext[SMALL_W-1:0];
                rm_next    = rel_reg;
                on_next    = ovf_reg;
                tick_next  = tick_reg + 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            task_reg     <= '0;
            scan_reg     <= '0;
            pipe_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
            comp_reg     <= '0;
            miss_reg     <= '0;
            run_reg      <= '0;
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                setup_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                phase_reg[i] <= '0;
                last_reg[i]  <= (TW + 1)'(SPORADIC_START);
            end
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            task_reg     <= task_next;
            scan_reg     <= scan_next;
            pipe_vld_reg <= pipe_vld_next;
            done_reg     <= done_next;
            comp_reg     <= comp_next;
            miss_reg     <= miss_next;
            run_reg      <= run_next;
            setup_reg    <= setup_next;
            phase_reg    <= phase_next;
            last_reg     <= last_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        grant_reg      <= grant_next;
        pipe_slot_reg  <= pipe_slot_next;
        best_found_reg <= best_found_next;
        best_slot_reg  <= best_slot_next;
        best_dl_reg    <= best_dl_next;
        best_task_reg  <= best_task_next;
        best_rem_reg   <= best_rem_next;
        live_reg       <= live_next;
        exp_reg        <= exp_next;
        ovf_reg        <= ovf_next;
        rel_reg        <= rel_next;
        sv_reg         <= sv_next;
        st_reg         <= st_next;
        oc_reg         <= oc_next;
        rm_reg         <= rm_next;
        en_reg         <= en_next;
        on_reg         <= on_next;
        jp_reg         <= jp_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign served_valid    = sv_reg;
    assign served_task     = st_reg;
    assign service_outcome = oc_reg;
    assign released_mask   = rm_reg;
    assign expired_now     = en_reg;
    assign overflow_now    = on_reg;
    assign jobs_pending    = jp_reg;
    assign total_completed = comp_reg;
    assign total_missed    = miss_reg;
    assign total_running   = run_reg;

endmodule

/* src/edfs_job_store.sv */
// ----------------------------------------------------------------------------
// edfs_job_store
// Job slots: valid flags in flops, deadline/remaining/task in a memory with
// one write and one registered read port, plus the lowest-free-slot search.
// ----------------------------------------------------------------------------
module edfs_job_store #(
    parameter int DEPTH  = edfs_pkg::DEF_QUEUE_DEPTH,
    parameter int TW     = edfs_pkg::DEF_TICK_WIDTH,
    parameter int SW     = edfs_pkg::DEF_SPAN_WIDTH,
    parameter int SLOT_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  edfs_pkg::store_ctl_t        ctl,
    input  logic [SLOT_W-1:0]           wr_slot,
    input  logic [TW-1:0]               wr_deadline,
    input  logic [SW-1:0]               wr_rem,
    input  logic [edfs_pkg::TASK_W-1:0] wr_task,
    input  logic [SLOT_W-1:0]           rd_slot,
    output logic [TW-1:0]               rd_deadline,
    output logic [SW-1:0]               rd_rem,
    output logic [edfs_pkg::TASK_W-1:0] rd_task,
    output logic [DEPTH-1:0]            valid,
    output logic                        free_found,
    output logic [SLOT_W-1:0]           free_slot
);
    import edfs_pkg::*;

    logic [DEPTH-1:0]  valid_reg;
    logic [TW-1:0]     dl_mem   [DEPTH];
    logic [SW-1:0]     rem_mem  [DEPTH];
    logic [TASK_W-1:0] task_mem [DEPTH];

    // set or drop the valid flag of one slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ctl.set_vld)
            begin
                valid_reg[wr_slot] <= 1'b1;
            end
            if (ctl.clr_vld)
            begin
                valid_reg[wr_slot] <= 1'b0;
            end
        end
    end

    // write entry fields
    always_ff @(posedge clk)
    begin
        if (ctl.wr_entry)
        begin
            dl_mem[wr_slot]   <= wr_deadline;
            rem_mem[wr_slot]  <= wr_rem;
            task_mem[wr_slot] <= wr_task;
        end
        else if (ctl.wr_rem)
        begin
            rem_mem[wr_slot] <= wr_rem;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_deadline <= dl_mem[rd_slot];
        rd_rem      <= rem_mem[rd_slot];
        rd_task     <= task_mem[rd_slot];
    end

    // find the lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    assign valid = valid_reg;

endmodule

/* src/edfs_checker.sv */
// ----------------------------------------------------------------------------
// edfs_checker
// Port-level checks of the EDF task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`include "edf_task_scheduler_unit_assert.svh"

module edfs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic                         served_valid,
    input logic [1:0]                   service_outcome,
    input logic [edfs_pkg::TOTAL_W-1:0] total_completed
);
    import edfs_pkg::*;

    // a taken command starts work
    `EDFS_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)

    // a result shows only once work is over
    `EDFS_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)

    // one strobe per tick
    `EDFS_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)

    // served flag agrees with the outcome code
    `EDFS_ASSERT_IMP(a_served_code, clk, rst_n, done,
        served_valid == (service_outcome != OUT_IDLE))

    // completed total moves only with a completion
    `EDFS_ASSERT_IMP(a_comp_total, clk, rst_n,
        done && (service_outcome != OUT_DONE), $stable(total_completed))

endmodule

bind edf_task_scheduler_unit edfs_checker u_edfs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .served_valid    (served_valid),
    .service_outcome (service_outcome),
    .total_completed (total_completed)
);

/* tb/tb_edf_task_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// tb_edf_task_scheduler_unit
// Drives scheduler ticks with random sporadic grants over a series of task
// setups, predicts every tick result with a local EDF model and compares each
// done word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_edf_task_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import edfs_pkg::*;

    localparam int NTASK     = 8;
    localparam int NSLOT     = 32;
    localparam int WD_LIMIT  = 5000;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_AW-1:0]    addr;
        logic [CFG_WIDTH-1:0] data;
        logic [GRANT_W-1:0]   grant;
        int                   idle_pct;
    } work_t;

    typedef struct {
        logic               served_valid;
        logic [TASK_W-1:0]  served_task;
        outcome_t           outcome;
        logic [GRANT_W-1:0] released;
        logic [SMALL_W-1:0] expired;
        logic [OVF_W-1:0]   overflow;
        logic [SMALL_W-1:0] pending;
        logic [TOTAL_W-1:0] completed;
        logic [TOTAL_W-1:0] missed;
        logic [TOTAL_W-1:0] running;
    } tick_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic wr_en = 1'b0;
    logic [CFG_AW-1:0] wr_addr = '0;
    logic [CFG_WIDTH-1:0] wr_data = '0;
    logic [GRANT_W-1:0] sporadic_grant = '0;
    logic busy, done, served_valid;
    logic [TASK_W-1:0] served_task;
    logic [1:0] service_outcome;
    logic [GRANT_W-1:0] released_mask;
    logic [SMALL_W-1:0] expired_now, jobs_pending;
    logic [OVF_W-1:0] overflow_now;
    logic [TOTAL_W-1:0] total_completed, total_missed, total_running;

    work_t      work_q[$];
    tick_word_t tick_word_q[$];
    bit         failed = 1'b0;
    int         quiet_cycles = 0;

    // scheduler model state
    logic [CFG_WIDTH-1:0] m_setup[NTASK];
    logic [31:0]          m_tick;
    int                   m_phase[NTASK];
    longint               m_last_rel[NTASK];
    bit                   m_valid[NSLOT];
    logic [31:0]          m_deadline[NSLOT];
    logic [15:0]          m_remain[NSLOT];
    logic [2:0]           m_task[NSLOT];
    logic [TOTAL_W-1:0]   m_completed, m_missed, m_running;

    edf_task_scheduler_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .sporadic_grant(sporadic_grant), .served_valid(served_valid),
        .served_task(served_task), .service_outcome(service_outcome),
        .released_mask(released_mask), .expired_now(expired_now),
        .overflow_now(overflow_now), .jobs_pending(jobs_pending),
        .total_completed(total_completed), .total_missed(total_missed),
        .total_running(total_running)
    );

    always #10 clk = ~clk;

    function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // run one tick of the EDF model and queue its result word
    task automatic schedule_tick(input logic [GRANT_W-1:0] grant);
        tick_word_t w;
        int period, budget, s, best, free_slot;
        bit fire;
        w = '{default: '0};
        best = -1;
        for (int t = 0; t < NTASK; t++) begin
            period = m_setup[t][15:0];
            budget = m_setup[t][31:16];
            fire = 1'b0;
            if (period == 0) begin
                m_phase[t] = 0;
                continue;
            end
            if (m_setup[t][PERIODIC_BIT]) begin
                fire = (m_phase[t] == 0);
            end
            else if (longint'(m_tick) - m_last_rel[t] >= period && grant[t]) begin
                fire = 1'b1;
                m_last_rel[t] = longint'(m_tick);
            end
            m_phase[t] = (m_phase[t] + 1 >= period) ? 0 : m_phase[t] + 1;
            if (fire) begin
                w.released[t] = 1'b1;
                free_slot = -1;
                for (s = 0; s < NSLOT; s++) begin
                    if (!m_valid[s]) begin
                        free_slot = s;
                        break;
                    end
                end
                if (free_slot >= 0) begin
                    m_valid[free_slot]    = 1'b1;
                    m_deadline[free_slot] = m_tick + 32'(period);
                    m_remain[free_slot]   = 16'(budget);
                    m_task[free_slot]     = 3'(t);
                end
                else begin
                    w.overflow++;
                end
            end
        end
        // drop expired unfinished jobs
        for (s = 0; s < NSLOT; s++) begin
            if (m_valid[s] && m_deadline[s] <= m_tick && m_remain[s] > 0) begin
                m_valid[s] = 1'b0;
                w.expired++;
                m_missed = bump(m_missed);
            end
        end
        // pick earliest deadline, lower task on a tie
        for (s = 0; s < NSLOT; s++) begin
            if (!m_valid[s]) continue;
            if (best < 0 || m_deadline[s] < m_deadline[best] ||
                (m_deadline[s] == m_deadline[best] && m_task[s] < m_task[best]))
                best = s;
        end
        if (best >= 0) begin
            w.served_valid = 1'b1;
            w.served_task  = m_task[best];
            if (m_remain[best] > 0) m_remain[best]--;
            if (m_remain[best] == 0) begin
                w.outcome = OUT_DONE;
                m_valid[best] = 1'b0;
                m_completed = bump(m_completed);
            end
            else if (m_deadline[best] == m_tick) begin
                w.outcome = OUT_MISS;
                m_valid[best] = 1'b0;
                m_missed = bump(m_missed);
            end
            else begin
                w.outcome = OUT_RUN;
                m_running = bump(m_running);
            end
        end
        for (s = 0; s < NSLOT; s++) if (m_valid[s]) w.pending++;
        m_tick++;
        w.completed = m_completed;
        w.missed    = m_missed;
        w.running   = m_running;
        tick_word_q.push_back(w);
    endtask

    task automatic add_setup(input int t, input logic [CFG_WIDTH-1:0] v);
        work_q.push_back('{1'b1, 3'(t), v, '0, 0});
    endtask

    task automatic add_tick(input logic [GRANT_W-1:0] g, input int pct);
        work_q.push_back('{1'b0, '0, '0, g, pct});
    endtask

    function automatic logic [CFG_WIDTH-1:0] pack_setup(input int p, input int b,
                                                        input bit per);
        return {per, 16'(b), 16'(p)};
    endfunction

    // driver: launch ticks, write setups only when nothing is in flight
    always @(posedge clk) begin
        bit acc, nxt_start, nxt_wr;
        acc = 1'b0;
        nxt_start = 1'b0;
        nxt_wr = 1'b0;
        if (rst_n) begin
            acc = start && !busy;
            if (acc) begin
                schedule_tick(sporadic_grant);
                void'(work_q.pop_front());
            end
            if (start && !acc) begin
                nxt_start = 1'b1;
            end
            else if (work_q.size() != 0) begin
                if (work_q[0].is_cfg) begin
                    if (!acc && !start && !busy && tick_word_q.size() == 0) begin
                        nxt_wr = 1'b1;
                        wr_addr <= work_q[0].addr;
                        wr_data <= work_q[0].data;
                        m_setup[work_q[0].addr] = work_q[0].data;
                        void'(work_q.pop_front());
                    end
                end
                else if ($urandom_range(99) >= work_q[0].idle_pct) begin
                    nxt_start = 1'b1;
                    sporadic_grant <= work_q[0].grant;
                end
            end
        end
        start <= nxt_start;
        wr_en <= nxt_wr;
    end

    // monitor: compare each done word with the oldest prediction
    always @(posedge clk) begin
        tick_word_t e;
        if (rst_n && done) begin
            if (tick_word_q.size() == 0) begin
                $display("%0t: unexpected tick word", $time);
                failed = 1'b1;
            end
            else begin
                e = tick_word_q.pop_front();
                if (served_valid !== e.served_valid) begin
                    $display("%0t: served_valid exp %0d got %0d", $time,
                             e.served_valid, served_valid);
                    failed = 1'b1;
                end
                if (served_task !== e.served_task) begin
                    $display("%0t: served_task exp %0d got %0d", $time,
                             e.served_task, served_task);
                    failed = 1'b1;
                end
                if (service_outcome !== e.outcome) begin
                    $display("%0t: service_outcome exp %0d got %0d", $time,
                             e.outcome, service_outcome);
                    failed = 1'b1;
                end
                if (released_mask !== e.released) begin
                    $display("%0t: released_mask exp %h got %h", $time,
                             e.released, released_mask);
                    failed = 1'b1;
                end
                if (expired_now !== e.expired) begin
                    $display("%0t: expired_now exp %0d got %0d", $time,
                             e.expired, expired_now);
                    failed = 1'b1;
                end
                if (overflow_now !== e.overflow) begin
                    $display("%0t: overflow_now exp %0d got %0d", $time,
                             e.overflow, overflow_now);
                    failed = 1'b1;
                end
                if (jobs_pending !== e.pending) begin
                    $display("%0t: jobs_pending exp %0d got %0d", $time,
                             e.pending, jobs_pending);
                    failed = 1'b1;
                end
                if (total_completed !== e.completed) begin
                    $display("%0t: total_completed exp %0d got %0d", $time,
                             e.completed, total_completed);
                    failed = 1'b1;
                end
                if (total_missed !== e.missed) begin
                    $display("%0t: total_missed exp %0d got %0d", $time,
                             e.missed, total_missed);
                    failed = 1'b1;
                end
                if (total_running !== e.running) begin
                    $display("%0t: total_running exp %0d got %0d", $time,
                             e.running, total_running);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog: stop when nothing moves for too long
    always @(posedge clk) begin
        if ((start && !busy) || done || wr_en || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int pcts[4];
        int p, b;
        pcts = '{0, 58, 0, 28};
        // model reset
        m_tick = '0;
        m_completed = '0;
        m_missed = '0;
        m_running = '0;
        for (int t = 0; t < NTASK; t++) begin
            m_setup[t] = '0;
            m_phase[t] = 0;
            m_last_rel[t] = SPORADIC_START;
        end
        for (int s = 0; s < NSLOT; s++) m_valid[s] = 1'b0;

        // all tasks disabled: idle ticks
        add_tick(8'hFF, 0);
        add_tick(8'h00, 0);
        // periodic period 1, large budget: every task releases on every tick and its jobs expire unfinished
        for (int t = 0; t < NTASK; t++) add_setup(t, pack_setup(1, 16'hFFFF, 1'b1));
        for (int i = 0; i < 6; i++) add_tick(8'h00, 0);
        // sporadic, zero budget, extreme period, budget beyond period
        add_setup(0, pack_setup(2, 0, 1'b0));
        add_setup(1, pack_setup(16'hFFFF, 16'hFFFF, 1'b0));
        add_setup(2, pack_setup(3, 5, 1'b1));
        add_setup(3, pack_setup(0, 4, 1'b1));
        add_setup(4, pack_setup(1, 1, 1'b0));
        add_setup(5, pack_setup(2, 2, 1'b1));
        add_setup(6, pack_setup(5, 0, 1'b1));
        add_setup(7, pack_setup(4, 3, 1'b0));
        for (int i = 0; i < 12; i++) add_tick(8'(i[0] ? 8'hFF : 8'h55 << i[1]), 0);

        // random setups, each followed by a run of ticks
        for (int ph = 0; ph < 12; ph++) begin
            for (int t = 0; t < NTASK; t++) begin
                case ($urandom_range(5))
                    0: p = 0;
                    1: p = $urandom_range(16'hFFFF);
                    default: p = $urandom_range(1, 12);
                endcase
                b = ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                             : $urandom_range(0, 6);
                add_setup(t, pack_setup(p, b, $urandom_range(1)));
            end
            for (int i = 0; i < 73; i++)
                add_tick(($urandom_range(4) == 0) ? 8'hFF : 8'($urandom),
                         pcts[ph % 4]);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (work_q.size() == 0 && tick_word_q.size() == 0);
        repeat (60) @(posedge clk);
        if (!failed)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
